// ===== rtl/sec2cal_pkg.sv =====
// ----------------------------------------------------------------------------
// sec2cal_pkg
// Constants, tables and digit helpers for the seconds to calendar converter.
// ----------------------------------------------------------------------------
package sec2cal_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned MonthCount  = 12;

  // Reciprocals: floor(x / d) == (x * M) >> K for the stated input range.
  // Day:  (count >> 7) / 675, 25-bit input.
  localparam logic [25:0] DayRecip   = 26'd50903317;
  localparam int unsigned DayShift   = 35;
  // Hour: (tod >> 4) / 225, 13-bit input.
  localparam logic [13:0] HourRecip  = 14'd9321;
  localparam int unsigned HourShift  = 21;
  // Year: days / 365, 16-bit input.
  localparam logic [16:0] YearRecip  = 17'd91930;
  localparam int unsigned YearShift  = 25;
  // Minute: (rem >> 2) / 15, 10-bit input.
  localparam logic [10:0] MinRecip   = 11'd1093;
  localparam int unsigned MinShift   = 14;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  // First day of year of each month, non-leap.
  function automatic logic [8:0] month_first(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Two decimal digits of a value below 64.
  function automatic digits_t split_digits(input logic [5:0] v);
    logic [13:0] prod;
    logic [5:0]  tens_x10;
    digits_t     d;
    prod     = 14'(v) * 14'd205;
    d.tens   = prod[13:11];
    tens_x10 = 6'(d.tens) * 6'd10;
    d.ones   = 4'(v - tens_x10);
    return d;
  endfunction

endpackage

// ===== rtl/seconds_to_calendar_time.sv =====
// ----------------------------------------------------------------------------
// seconds_to_calendar_time
// Converts an elapsed-seconds count into month, day and time of day digits.
// ----------------------------------------------------------------------------
// Usage:
//   Drive elapsed_seconds_i and raise start_i for one cycle per item. busy_o
//   is always low, so an item is taken on every cycle that start_i is high.
//   Each item comes out after passing all stages, with done_o high for one cycle and
//   the month, day and hh:mm:ss digits on the result ports.
//   Throughput: one item per cycle. The reciprocal multiplies, remainder
//   subtracts and digit splits are spread over the register stages.
//   The date wraps every 365 days; February always has 28 days.
//   Reset clears the stage valid bits, so no item in flight survives it and
//   done_o stays low until a new item has passed all stages.
//   The receiver cannot stall: results are shown for exactly one cycle and
//   must be taken then.
// ----------------------------------------------------------------------------
module seconds_to_calendar_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] elapsed_seconds_i,
  output logic        done_o,
  output logic [3:0]  month_o,
  output logic [1:0]  day_tens_o,
  output logic [3:0]  day_ones_o,
  output logic [1:0]  hour_tens_o,
  output logic [3:0]  hour_ones_o,
  output logic [2:0]  minute_tens_o,
  output logic [3:0]  minute_ones_o,
  output logic [2:0]  second_tens_o,
  output logic [3:0]  second_ones_o
);

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] vld_q, vld_d;
  logic              accept;

  // stage 1
  logic [50:0] s1_prod_q, s1_prod_d;
  logic [31:0] s1_cnt_q;
  // stage 2
  logic [15:0] s2_days_q, s2_days_d;
  logic [16:0] s2_tod_q, s2_tod_d;
  logic [31:0] s2_dsec;
  logic [31:0] s2_tod_full;
  // stage 3
  logic [15:0] s3_days_q;
  logic [16:0] s3_tod_q;
  logic [4:0]  s3_hh_q, s3_hh_d;
  logic [7:0]  s3_yq_q, s3_yq_d;
  logic [26:0] s3_hprod;
  logic [32:0] s3_yprod;
  // stage 4
  logic [8:0]  s4_yday_q, s4_yday_d;
  logic [11:0] s4_rem_q, s4_rem_d;
  logic [4:0]  s4_hh_q;
  logic [15:0] s4_ysub;
  logic [16:0] s4_rsub;
  // stage 5
  logic [3:0]  s5_mon_q, s5_mon_d;
  logic [5:0]  s5_mm_q, s5_mm_d;
  logic [8:0]  s5_yday_q;
  logic [11:0] s5_rem_q;
  sec2cal_pkg::digits_t s5_hh_q, s5_hh_d;
  logic [20:0] s5_mprod;
  // stage 6
  logic [5:0]  s6_ss_q, s6_ss_d;
  logic [4:0]  s6_mday_q, s6_mday_d;
  logic [3:0]  s6_mon_q;
  sec2cal_pkg::digits_t s6_hh_q, s6_mm_q, s6_mm_d;
  logic [11:0] s6_ssub;
  logic [8:0]  s6_dsub;
  // stage 7
  sec2cal_pkg::digits_t s7_ss_d, s7_day_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign vld_d  = {vld_q[Stages-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: whole days, reciprocal product
  assign s1_prod_d = 51'(elapsed_seconds_i[31:7]) * 51'(sec2cal_pkg::DayRecip);

  // stage 2: day count and time of day
  assign s2_days_d   = s1_prod_q[sec2cal_pkg::DayShift +: 16];
  assign s2_dsec     = 32'(s2_days_d) * 32'(sec2cal_pkg::SecsPerDay);
  assign s2_tod_full = s1_cnt_q - s2_dsec;
  assign s2_tod_d    = s2_tod_full[16:0];

  // stage 3: hour and years elapsed
  assign s3_hprod = 27'(s2_tod_q[16:4]) * 27'(sec2cal_pkg::HourRecip);
  assign s3_hh_d  = s3_hprod[sec2cal_pkg::HourShift +: 5];
  assign s3_yprod = 33'(s2_days_q) * 33'(sec2cal_pkg::YearRecip);
  assign s3_yq_d  = s3_yprod[sec2cal_pkg::YearShift +: 8];

  // stage 4: day of year, seconds within hour
  assign s4_ysub   = s3_days_q - 16'(s3_yq_q) * 16'(sec2cal_pkg::DaysPerYear);
  assign s4_yday_d = s4_ysub[8:0];
  assign s4_rsub   = s3_tod_q - 17'(s3_hh_q) * 17'(sec2cal_pkg::SecsPerHour);
  assign s4_rem_d  = s4_rsub[11:0];

  // stage 5: month, minute, hour digits
  always_comb begin
    s5_mon_d = 4'd0;
    for (int k = 1; k < sec2cal_pkg::MonthCount; k++) begin
      if (s4_yday_q >= sec2cal_pkg::month_first(4'(k))) begin
        s5_mon_d = 4'(k);
      end
    end
  end

  assign s5_mprod = 21'(s4_rem_q[11:2]) * 21'(sec2cal_pkg::MinRecip);
  assign s5_mm_d  = s5_mprod[sec2cal_pkg::MinShift +: 6];
  assign s5_hh_d  = sec2cal_pkg::split_digits({1'b0, s4_hh_q});

  // stage 6: second, day of month, minute digits
  assign s6_ssub   = s5_rem_q - 12'(s5_mm_q) * 12'(sec2cal_pkg::SecsPerMin);
  assign s6_ss_d   = s6_ssub[5:0];
  assign s6_dsub   = s5_yday_q - sec2cal_pkg::month_first(s5_mon_q) + 9'd1;
  assign s6_mday_d = s6_dsub[4:0];
  assign s6_mm_d   = sec2cal_pkg::split_digits(s5_mm_q);

  // stage 7: remaining digits into the output registers
  assign s7_ss_d  = sec2cal_pkg::split_digits(s6_ss_q);
  assign s7_day_d = sec2cal_pkg::split_digits({1'b0, s6_mday_q});

  always_ff @(posedge clk_i) begin
    s1_prod_q     <= s1_prod_d;
    s1_cnt_q      <= elapsed_seconds_i;
    s2_days_q     <= s2_days_d;
    s2_tod_q      <= s2_tod_d;
    s3_days_q     <= s2_days_q;
    s3_tod_q      <= s2_tod_q;
    s3_hh_q       <= s3_hh_d;
    s3_yq_q       <= s3_yq_d;
    s4_yday_q     <= s4_yday_d;
    s4_rem_q      <= s4_rem_d;
    s4_hh_q       <= s3_hh_q;
    s5_mon_q      <= s5_mon_d;
    s5_mm_q       <= s5_mm_d;
    s5_yday_q     <= s4_yday_q;
    s5_rem_q      <= s4_rem_q;
    s5_hh_q       <= s5_hh_d;
    s6_ss_q       <= s6_ss_d;
    s6_mday_q     <= s6_mday_d;
    s6_mon_q      <= s5_mon_q;
    s6_hh_q       <= s5_hh_q;
    s6_mm_q       <= s6_mm_d;
    month_o       <= s6_mon_q + 4'd1;
    day_tens_o    <= s7_day_d.tens[1:0];
    day_ones_o    <= s7_day_d.ones;
    hour_tens_o   <= s6_hh_q.tens[1:0];
    hour_ones_o   <= s6_hh_q.ones;
    minute_tens_o <= s6_mm_q.tens;
    minute_ones_o <= s6_mm_q.ones;
    second_tens_o <= s7_ss_d.tens;
    second_ones_o <= s7_ss_d.ones;
  end

  assign done_o = vld_q[Stages-1];

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the seconds to calendar time converter.
// Drives elapsed-second counts (directed corner cases, then random counts
// biased toward day and month boundaries) with random idle cycles. Predicts
// the non-leap date and time-of-day digits, and checks every done strobe in
// order against the prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned DaySecs    = 86400;
  localparam int unsigned HourSecs   = 3600;
  localparam int unsigned MinSecs    = 60;
  localparam int unsigned YearDays   = 365;
  localparam int unsigned RandItems  = 680;
  localparam int unsigned StallLimit = 1000;

  typedef struct packed {
    logic [3:0] month;
    logic [1:0] day_tens;
    logic [3:0] day_ones;
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
  } calendar_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] elapsed_seconds_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [3:0]  month_o;
  logic [1:0]  day_tens_o;
  logic [3:0]  day_ones_o;
  logic [1:0]  hour_tens_o;
  logic [3:0]  hour_ones_o;
  logic [2:0]  minute_tens_o;
  logic [3:0]  minute_ones_o;
  logic [2:0]  second_tens_o;
  logic [3:0]  second_ones_o;

  logic [31:0]  pending_counts [$];
  bit           pending_drain  [$];
  calendar_t    calendar_due   [$];
  int unsigned  month_start    [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  logic         taken_q = 1'b0;
  int unsigned  items_sent = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  error_count = 0;

  seconds_to_calendar_time i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .elapsed_seconds_i (elapsed_seconds_i),
    .done_o            (done_o),
    .month_o           (month_o),
    .day_tens_o        (day_tens_o),
    .day_ones_o        (day_ones_o),
    .hour_tens_o       (hour_tens_o),
    .hour_ones_o       (hour_ones_o),
    .minute_tens_o     (minute_tens_o),
    .minute_ones_o     (minute_ones_o),
    .second_tens_o     (second_tens_o),
    .second_ones_o     (second_ones_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic calendar_t to_calendar(input logic [31:0] secs);
    int unsigned yday, tod, hh, mm, ss, mon, mday;
    calendar_t   c;
    yday = (secs / DaySecs) % YearDays;
    tod  = secs % DaySecs;
    hh   = tod / HourSecs;
    mm   = (tod % HourSecs) / MinSecs;
    ss   = tod % MinSecs;
    mon  = 0;
    for (int k = 1; k < 12; k++) begin
      if (yday >= month_start[k]) mon = k;
    end
    mday = yday - month_start[mon] + 1;
    c.month       = 4'(mon + 1);
    c.day_tens    = 2'(mday / 10);
    c.day_ones    = 4'(mday % 10);
    c.hour_tens   = 2'(hh / 10);
    c.hour_ones   = 4'(hh % 10);
    c.minute_tens = 3'(mm / 10);
    c.minute_ones = 4'(mm % 10);
    c.second_tens = 3'(ss / 10);
    c.second_ones = 4'(ss % 10);
    return c;
  endfunction

  task automatic queue_count(input logic [31:0] secs, input bit drain);
    pending_counts.push_back(secs);
    pending_drain.push_back(drain);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: a new item goes out at the falling edge once the last one is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || taken_q)) begin
      if (pending_counts.size() != 0 &&
          !(pending_drain[0] && calendar_due.size() != 0) &&
          ((items_sent >= 300 && items_sent < 450) || $urandom_range(0, 99) >= 6)) begin
        void'(pending_drain.pop_front());
        elapsed_seconds_i <= pending_counts.pop_front();
        start_i           <= 1'b1;
        items_sent        <= items_sent + 1;
      end else begin
        elapsed_seconds_i <= $urandom();
        start_i           <= 1'b0;
      end
    end
  end

  // Monitor, checker and watchdog.
  always @(posedge clk_i) begin
    calendar_t want;
    if (rst_ni) begin
      taken_q <= start_i && !busy_o;
      if (start_i && !busy_o) calendar_due.push_back(to_calendar(elapsed_seconds_i));
      if (done_o) begin
        if (calendar_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %0d/%0d%0d %0d%0d:%0d%0d:%0d%0d",
                   $time, month_o, day_tens_o, day_ones_o, hour_tens_o, hour_ones_o,
                   minute_tens_o, minute_ones_o, second_tens_o, second_ones_o);
        end else begin
          want = calendar_due.pop_front();
          check_field("month",       32'(want.month),       32'(month_o));
          check_field("day_tens",    32'(want.day_tens),    32'(day_tens_o));
          check_field("day_ones",    32'(want.day_ones),    32'(day_ones_o));
          check_field("hour_tens",   32'(want.hour_tens),   32'(hour_tens_o));
          check_field("hour_ones",   32'(want.hour_ones),   32'(hour_ones_o));
          check_field("minute_tens", 32'(want.minute_tens), 32'(minute_tens_o));
          check_field("minute_ones", 32'(want.minute_ones), 32'(minute_ones_o));
          check_field("second_tens", 32'(want.second_tens), 32'(second_tens_o));
          check_field("second_ones", 32'(want.second_ones), 32'(second_ones_o));
        end
      end
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("%0t: no item or result for %0d cycles", $time, StallLimit);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int          sel, day;
    int unsigned tod;
    // Directed: field extremes, digit rollovers, month edges and year wrap.
    queue_count(32'd0, 1'b0);
    queue_count(32'hFFFF_FFFF, 1'b0);
    queue_count(32'h5555_5555, 1'b0);
    queue_count(32'hAAAA_AAAA, 1'b0);
    queue_count(32'h8000_0000, 1'b0);
    queue_count(DaySecs - 1, 1'b0);
    queue_count(DaySecs, 1'b0);
    queue_count(9 * HourSecs + 59 * MinSecs + 59, 1'b0);
    queue_count(19 * HourSecs + 9 * MinSecs + 9, 1'b0);
    queue_count(20 * HourSecs + 10 * MinSecs + 10, 1'b0);
    queue_count(9 * DaySecs, 1'b0);
    queue_count(29 * DaySecs + 12 * HourSecs, 1'b0);
    queue_count(31 * DaySecs - 1, 1'b0);
    queue_count(31 * DaySecs, 1'b0);
    queue_count(59 * DaySecs - 1, 1'b0);
    queue_count(59 * DaySecs, 1'b0);
    queue_count(334 * DaySecs - 1, 1'b0);
    queue_count(334 * DaySecs, 1'b0);
    queue_count(YearDays * DaySecs - 1, 1'b0);
    queue_count(YearDays * DaySecs, 1'b0);
    queue_count(7 * YearDays * DaySecs + 243 * DaySecs + 1, 1'b1);
    // Random: raw counts, day counts plus a time of day, and counts near month starts.
    for (int n = 0; n < RandItems; n++) begin
      sel = $urandom_range(0, 3);
      tod = $urandom_range(0, DaySecs - 1);
      if ($urandom_range(0, 3) == 0) tod = ($urandom_range(0, 1) == 0) ? 0 : DaySecs - 1;
      if (sel == 0) begin
        queue_count($urandom(), n == 250 || n == 500);
      end else if (sel == 3) begin
        day = $urandom_range(0, 135) * YearDays + month_start[$urandom_range(0, 11)]
              + $urandom_range(0, 2) - 1;
        if (day < 0) day = 0;
        queue_count(32'(day) * DaySecs + tod, n == 250 || n == 500);
      end else begin
        queue_count(32'($urandom_range(0, 49709)) * DaySecs + tod, n == 250 || n == 500);
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_counts.size() != 0 || start_i || calendar_due.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_count == 0 && calendar_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
